// File: hw/rtl/pfsp_pkg.sv
// ----------------------------------------------------------------------------
// pfsp_pkg
// Shared types and character codes for the format signature parser.
// ----------------------------------------------------------------------------
package pfsp_pkg;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRAILING  = 3'd1,
    ST_MIXED     = 3'd2,
    ST_RANGE     = 3'd3,
    ST_PERCENT_N = 3'd4,
    ST_BAD_CONV  = 3'd5,
    ST_CONFLICT  = 3'd6
  } status_e;

  // argument classes
  localparam logic [1:0] CLS_NONE = 2'd0;
  localparam logic [1:0] CLS_NUM  = 2'd1;
  localparam logic [1:0] CLS_STR  = 2'd2;
  localparam logic [1:0] CLS_CHAR = 2'd3;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_L   = 8'h4C;
  localparam logic [7:0] CH_UP_X   = 8'h58;
  localparam logic [7:0] CH_C      = 8'h63;
  localparam logic [7:0] CH_D      = 8'h64;
  localparam logic [7:0] CH_H      = 8'h68;
  localparam logic [7:0] CH_I      = 8'h69;
  localparam logic [7:0] CH_J      = 8'h6A;
  localparam logic [7:0] CH_L      = 8'h6C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_O      = 8'h6F;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_Z      = 8'h7A;

  typedef struct packed {
    status_e     status;
    logic [3:0]  max_pos;
    logic [15:0] type_codes;
  } res_t;

endpackage

// File: hw/rtl/pfsp_parser.sv
// ----------------------------------------------------------------------------
// pfsp_parser
// Per-byte scanner state and its next-state logic; builds the result on
// the terminator and clears itself.
// ----------------------------------------------------------------------------
module pfsp_parser import pfsp_pkg::*; #(
  parameter int MAX_ARGS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [7:0] ch_i,
  output res_t       res_o
);

  localparam int CAP   = MAX_ARGS + 1;
  localparam int PW    = $clog2(CAP + 1);
  localparam int DW    = (PW > 4) ? PW : 4;
  localparam int IW    = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
  localparam int NCODE = (MAX_ARGS < 8) ? MAX_ARGS : 8;

  typedef enum logic [2:0] {
    PH_TEXT, PH_PCT, PH_POSDIG, PH_FLAGS, PH_WIDTH, PH_PREC, PH_LEN, PH_ERR
  } phase_e;

  phase_e        phase_q, phase_d, asg_next;
  logic [DW-1:0] digit_q, digit_d, pos;
  logic          dz_q, dz_d;
  logic [3:0]    cur_q, cur_d;
  logic [PW-1:0] ic_q, ic_d;
  logic          es_q, es_d, is_q, is_d;
  logic [3:0]    hp_q, hp_d;
  logic [1:0]    cls_q [MAX_ARGS];
  logic [1:0]    cls_d [MAX_ARGS];
  status_e       err_q, err_d;

  logic          is_dig, go, done, asg, asg_exp;
  logic [7:0]    acc;
  logic [1:0]    cls;
  logic          cls_ok;
  logic [3:0]    cur_m1;
  logic [IW-1:0] idx;
  logic [15:0]   codes;

  assign is_dig = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
  assign acc    = {{(8 - DW){1'b0}}, digit_q} * 8'd10 + (ch_i - CH_ZERO);

  always_comb begin
    phase_d = phase_q;
    digit_d = digit_q;
    dz_d    = dz_q;
    cur_d   = cur_q;
    ic_d    = ic_q;
    es_d    = es_q;
    is_d    = is_q;
    hp_d    = hp_q;
    cls_d   = cls_q;
    err_d   = err_q;
    go      = 1'b0;
    done    = 1'b0;
    asg     = 1'b0;
    asg_exp = 1'b0;
    asg_next = PH_FLAGS;
    pos     = '0;
    cls     = CLS_NONE;
    cls_ok  = 1'b0;
    cur_m1  = '0;
    idx     = '0;

    case (phase_q)
      PH_ERR: ;
      PH_TEXT: begin
        if (ch_i == CH_PCT) phase_d = PH_PCT;
      end
      PH_PCT: begin
        if (ch_i == CH_PCT) begin
          phase_d = PH_TEXT;
        end else if (ch_i == CH_NUL) begin
          err_d   = ST_TRAILING;
          phase_d = PH_ERR;
        end else if (is_dig) begin
          digit_d = DW'(ch_i - CH_ZERO);
          dz_d    = (ch_i == CH_ZERO);
          phase_d = PH_POSDIG;
        end else begin
          asg = 1'b1;
          go  = 1'b1;
        end
      end
      PH_POSDIG: begin
        if (is_dig) begin
          digit_d = (acc > 8'(CAP)) ? DW'(CAP) : acc[DW-1:0];
          if (ch_i != CH_ZERO) dz_d = 1'b0;
        end else if (ch_i == CH_DOLLAR) begin
          asg     = 1'b1;
          asg_exp = 1'b1;
        end else begin
          asg      = 1'b1;
          go       = 1'b1;
          asg_next = dz_q ? PH_FLAGS : PH_WIDTH;
        end
      end
      default: go = 1'b1;
    endcase

    // position assignment; at most one per byte
    if (asg) begin
      if (asg_exp) begin
        es_d = 1'b1;
        pos  = digit_q;
      end
      if (pos == '0) begin
        if (ic_q < PW'(CAP)) ic_d = ic_q + 1'b1;
        pos  = DW'(ic_d);
        is_d = 1'b1;
      end
      if (es_d && is_d) begin
        err_d   = ST_MIXED;
        phase_d = PH_ERR;
        go      = 1'b0;
      end else if (pos == '0 || pos > DW'(MAX_ARGS)) begin
        err_d   = ST_RANGE;
        phase_d = PH_ERR;
        go      = 1'b0;
      end else begin
        cur_d   = pos[3:0];
        phase_d = asg_next;
      end
    end

    // specifier tail: flags, width, precision, length, conversion
    if (go && phase_d == PH_FLAGS) begin
      if (ch_i == CH_MINUS || ch_i == CH_PLUS || ch_i == CH_SPACE ||
          ch_i == CH_HASH || ch_i == CH_ZERO) done = 1'b1;
      else phase_d = PH_WIDTH;
    end
    if (go && !done && phase_d == PH_WIDTH) begin
      if (is_dig) begin
        done = 1'b1;
      end else if (ch_i == CH_DOT) begin
        phase_d = PH_PREC;
        done    = 1'b1;
      end else begin
        phase_d = PH_LEN;
      end
    end
    if (go && !done && phase_d == PH_PREC) begin
      if (is_dig) done = 1'b1;
      else phase_d = PH_LEN;
    end
    if (go && !done && phase_d == PH_LEN) begin
      if (ch_i == CH_H || ch_i == CH_L || ch_i == CH_UP_L || ch_i == CH_Z ||
          ch_i == CH_J || ch_i == CH_T) begin
        done = 1'b1;
      end else begin
        cls_ok = 1'b1;
        case (ch_i)
          CH_D, CH_I, CH_U, CH_X, CH_UP_X, CH_O: cls = CLS_NUM;
          CH_S: cls = CLS_STR;
          CH_C: cls = CLS_CHAR;
          CH_N: begin
            cls_ok  = 1'b0;
            err_d   = ST_PERCENT_N;
            phase_d = PH_ERR;
          end
          default: begin
            cls_ok  = 1'b0;
            err_d   = ST_BAD_CONV;
            phase_d = PH_ERR;
          end
        endcase
        if (cls_ok) begin
          cur_m1 = cur_d - 4'd1;
          idx    = cur_m1[IW-1:0];
          if (cur_d == 4'd0 || cur_d > 4'(MAX_ARGS)) begin
            err_d   = ST_RANGE;
            phase_d = PH_ERR;
          end else if (cls_q[idx] != CLS_NONE && cls_q[idx] != cls) begin
            err_d   = ST_CONFLICT;
            phase_d = PH_ERR;
          end else begin
            cls_d[idx] = cls;
            if (cur_d > hp_q) hp_d = cur_d;
            phase_d = PH_TEXT;
          end
        end
      end
    end
  end

  always_comb begin
    codes = '0;
    for (int i = 0; i < NCODE; i++) codes[2*i +: 2] = cls_d[i];
    if (err_d == ST_OK) begin
      res_o.status     = ST_OK;
      res_o.max_pos    = hp_d;
      res_o.type_codes = codes;
    end else begin
      res_o.status     = err_d;
      res_o.max_pos    = '0;
      res_o.type_codes = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TEXT;
      digit_q <= '0;
      dz_q    <= 1'b1;
      cur_q   <= '0;
      ic_q    <= '0;
      es_q    <= 1'b0;
      is_q    <= 1'b0;
      hp_q    <= '0;
      err_q   <= ST_OK;
      for (int i = 0; i < MAX_ARGS; i++) cls_q[i] <= CLS_NONE;
    end else if (en_i) begin
      if (ch_i == CH_NUL) begin
        // terminator: result taken above, back to a clean slate
        phase_q <= PH_TEXT;
        digit_q <= '0;
        dz_q    <= 1'b1;
        cur_q   <= '0;
        ic_q    <= '0;
        es_q    <= 1'b0;
        is_q    <= 1'b0;
        hp_q    <= '0;
        err_q   <= ST_OK;
        for (int i = 0; i < MAX_ARGS; i++) cls_q[i] <= CLS_NONE;
      end else begin
        phase_q <= phase_d;
        digit_q <= digit_d;
        dz_q    <= dz_d;
        cur_q   <= cur_d;
        ic_q    <= ic_d;
        es_q    <= es_d;
        is_q    <= is_d;
        hp_q    <= hp_d;
        err_q   <= err_d;
        cls_q   <= cls_d;
      end
    end
  end

endmodule

// File: hw/rtl/printf_format_signature_parser.sv
// ----------------------------------------------------------------------------
// printf_format_signature_parser
// Scans a printf-style format string and reports its argument signature.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o, ch_i) takes one format byte per
//   transaction; a zero byte ends the string. Non-zero bytes yield nothing.
//   Output channel (out_valid_o/out_ready_i) carries one transaction per
//   string: status_o, max_pos_o (highest position used) and type_codes_o
//   (2 bits per position, position 1 lowest). On error the last two are 0.
//   Throughput: one byte per cycle while no terminator waits on the result
//   register; the parser update sits between the input and result registers.
//   Output: out_valid_o is registered, set as the terminator is parsed.
//   Stall: while a result waits, ordinary bytes keep flowing; a following
//   terminator holds in the input register until the result register frees.
//   Reset: all parser state cleared, both channels empty. Parser state also
//   clears after every terminator.
// ----------------------------------------------------------------------------
module printf_format_signature_parser import pfsp_pkg::*; #(
  parameter int MAX_ARGS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  ch_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [3:0]  max_pos_o,
  output logic [15:0] type_codes_o
);

  logic       in_vld_q;
  logic [7:0] ch_q;
  logic       out_vld_q;
  res_t       res_q, res;
  logic       out_free, s1_fire, is_term;

  assign is_term    = (ch_q == CH_NUL);
  assign out_free   = !out_vld_q || out_ready_i;
  assign s1_fire    = in_vld_q && (!is_term || out_free);
  assign in_ready_o = !in_vld_q || s1_fire;

  pfsp_parser #(
    .MAX_ARGS(MAX_ARGS)
  ) u_parser (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (s1_fire),
    .ch_i  (ch_q),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (s1_fire && is_term) out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) ch_q <= ch_i;
    if (s1_fire && is_term) res_q <= res;
  end

  assign out_valid_o  = out_vld_q;
  assign status_o     = res_q.status;
  assign max_pos_o    = res_q.max_pos;
  assign type_codes_o = res_q.type_codes;

endmodule

// File: sim/format_signature_checker.sv
// ----------------------------------------------------------------------------
// format_signature_checker
// Watches both channels of the format signature parser, runs its own parser
// on every accepted byte and compares each result transaction with the
// signature predicted at the matching terminator.
// ----------------------------------------------------------------------------
module format_signature_checker import pfsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  ch_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  status_i,
  input  logic [3:0]  max_pos_i,
  input  logic [15:0] type_codes_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ARG_SLOTS = 8;
  localparam int POS_CAP   = ARG_SLOTS + 1;

  typedef enum logic [2:0] {
    SCAN_TEXT,
    SCAN_PERCENT,
    SCAN_POSNUM,
    SCAN_FLAGS,
    SCAN_WIDTH,
    SCAN_PREC,
    SCAN_LEN,
    SCAN_HALT
  } scan_e;

  scan_e      phase;
  logic [3:0] acc;
  logic       all_zero;
  logic [3:0] cur_pos;
  logic [3:0] next_implicit;
  logic       saw_explicit;
  logic       saw_implicit;
  logic [3:0] top_pos;
  logic [1:0] slot_class [ARG_SLOTS];
  status_e    fault;

  res_t signatures_due[$];

  function automatic void clear_parser();
    phase         = SCAN_TEXT;
    acc           = 4'd0;
    all_zero      = 1'b1;
    cur_pos       = 4'd0;
    next_implicit = 4'd0;
    saw_explicit  = 1'b0;
    saw_implicit  = 1'b0;
    top_pos       = 4'd0;
    foreach (slot_class[k]) slot_class[k] = CLS_NONE;
    fault         = ST_OK;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // first error freezes the parse until the terminator
  function automatic void raise(status_e code);
    fault = code;
    phase = SCAN_HALT;
  endfunction

  function automatic bit take_position(bit from_dollar, logic [3:0] value);
    logic [3:0] pos;
    pos = 4'd0;
    if (from_dollar) begin
      saw_explicit = 1'b1;
      pos = value;
    end
    // "0$" falls back to implicit numbering
    if (pos == 4'd0) begin
      if (next_implicit < POS_CAP) next_implicit = next_implicit + 4'd1;
      pos = next_implicit;
      saw_implicit = 1'b1;
    end
    if (saw_explicit && saw_implicit) begin
      raise(ST_MIXED);
      return 1'b0;
    end
    if (pos < 1 || pos > ARG_SLOTS) begin
      raise(ST_RANGE);
      return 1'b0;
    end
    cur_pos = pos;
    return 1'b1;
  endfunction

  function automatic void convert_spec(logic [7:0] c);
    logic [1:0] kind;
    case (c)
      CH_D, CH_I, CH_U, CH_X, CH_UP_X, CH_O: kind = CLS_NUM;
      CH_S: kind = CLS_STR;
      CH_C: kind = CLS_CHAR;
      CH_N: begin
        raise(ST_PERCENT_N);
        return;
      end
      default: begin
        raise(ST_BAD_CONV);
        return;
      end
    endcase
    if (cur_pos < 1 || cur_pos > ARG_SLOTS) begin
      raise(ST_RANGE);
      return;
    end
    if (slot_class[cur_pos - 1] != CLS_NONE && slot_class[cur_pos - 1] != kind) begin
      raise(ST_CONFLICT);
      return;
    end
    slot_class[cur_pos - 1] = kind;
    if (cur_pos > top_pos) top_pos = cur_pos;
    phase = SCAN_TEXT;
  endfunction

  function automatic void scan_byte(logic [7:0] c);
    int acc_next;
    case (phase)
      SCAN_HALT: return;
      SCAN_TEXT: begin
        if (c == CH_PCT) phase = SCAN_PERCENT;
        return;
      end
      SCAN_PERCENT: begin
        if (c == CH_PCT) begin
          phase = SCAN_TEXT;
          return;
        end
        if (c == CH_NUL) begin
          raise(ST_TRAILING);
          return;
        end
        if (is_digit(c)) begin
          acc      = 4'(c - CH_ZERO);
          all_zero = (c == CH_ZERO);
          phase    = SCAN_POSNUM;
          return;
        end
        if (!take_position(1'b0, 4'd0)) return;
        phase = SCAN_FLAGS;
      end
      SCAN_POSNUM: begin
        if (is_digit(c)) begin
          acc_next = int'(acc) * 10 + int'(c - CH_ZERO);
          acc = (acc_next > POS_CAP) ? 4'(POS_CAP) : 4'(acc_next);
          if (c != CH_ZERO) all_zero = 1'b0;
          return;
        end
        if (c == CH_DOLLAR) begin
          if (take_position(1'b1, acc)) phase = SCAN_FLAGS;
          return;
        end
        // digits without '$' were a width; all-zero digits were flags
        if (!take_position(1'b0, 4'd0)) return;
        phase = all_zero ? SCAN_FLAGS : SCAN_WIDTH;
      end
      default: ;
    endcase

    // the current byte falls through the remaining specifier fields
    if (phase == SCAN_FLAGS) begin
      if (c == CH_MINUS || c == CH_PLUS || c == CH_SPACE || c == CH_HASH || c == CH_ZERO)
        return;
      phase = SCAN_WIDTH;
    end
    if (phase == SCAN_WIDTH) begin
      if (is_digit(c)) return;
      if (c == CH_DOT) begin
        phase = SCAN_PREC;
        return;
      end
      phase = SCAN_LEN;
    end
    if (phase == SCAN_PREC) begin
      if (is_digit(c)) return;
      phase = SCAN_LEN;
    end
    if (phase == SCAN_LEN) begin
      if (c == CH_H || c == CH_L || c == CH_UP_L || c == CH_Z || c == CH_J || c == CH_T)
        return;
      convert_spec(c);
    end
  endfunction

  function automatic res_t signature_of();
    res_t r;
    r.status     = fault;
    r.max_pos    = 4'd0;
    r.type_codes = '0;
    if (fault == ST_OK) begin
      r.max_pos = top_pos;
      for (int k = 0; k < ARG_SLOTS; k++) r.type_codes[2*k +: 2] = slot_class[k];
    end
    return r;
  endfunction

  initial clear_parser();

  always @(posedge clk_i) begin
    res_t want;
    int   errs;
    errs = 0;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (signatures_due.size() == 0) begin
          $error("result transaction with no terminated string waiting");
          errs++;
        end else begin
          want = signatures_due.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            errs++;
          end
          if (max_pos_i !== want.max_pos) begin
            $error("max_pos: expected %0d, got %0d", want.max_pos, max_pos_i);
            errs++;
          end
          if (type_codes_i !== want.type_codes) begin
            $error("type_codes: expected %h, got %h", want.type_codes, type_codes_i);
            errs++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        scan_byte(ch_i);
        if (ch_i == CH_NUL) begin
          signatures_due.push_back(signature_of());
          clear_parser();
        end
      end
    end
    fail_count_o <= fail_count_o + errs;
    pending_o    <= signatures_due.size();
  end

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Feeds format strings into the format signature parser: a few hand-picked
// strings for each error and corner, then random well-formed specifiers with
// some noise and broken strings, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb import pfsp_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_AFTER  = 9;    // results taken before the long receiver hold
  localparam int HOLD_CYCLES = 300;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  ch_i        = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [3:0]  max_pos_o;
  logic [15:0] type_codes_o;

  int   fail_count;
  int   pending;
  logic hold_active = 1'b0;
  logic tx_quiet    = 1'b0;
  int   bytes_sent  = 0;

  logic [7:0] fmt_bytes[$];

  logic [7:0] conv_chars [8] = '{CH_D, CH_I, CH_U, CH_X, CH_UP_X, CH_O, CH_S, CH_C};
  logic [7:0] flag_chars [5] = '{CH_MINUS, CH_PLUS, CH_SPACE, CH_HASH, CH_ZERO};
  logic [7:0] len_chars  [6] = '{CH_H, CH_L, CH_UP_L, CH_Z, CH_J, CH_T};

  always #10 clk_i = ~clk_i;

  printf_format_signature_parser DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .ch_i         (ch_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .max_pos_o    (max_pos_o),
    .type_codes_o (type_codes_o)
  );

  format_signature_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .ch_i         (ch_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_i     (status_o),
    .max_pos_i    (max_pos_o),
    .type_codes_i (type_codes_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic void add_chars(string s);
    for (int i = 0; i < s.len(); i++) fmt_bytes.push_back(s[i]);
  endfunction

  function automatic void add_number(int n);
    int div;
    div = 1;
    while (div * 10 <= n) div *= 10;
    while (div > 0) begin
      fmt_bytes.push_back(CH_ZERO + 8'((n / div) % 10));
      div /= 10;
    end
  endfunction

  function automatic void add_literal();
    logic [7:0] b;
    repeat ($urandom_range(1, 3)) begin
      b = 8'($urandom_range(1, 255));
      fmt_bytes.push_back(b);
      if (b == CH_PCT) fmt_bytes.push_back(CH_PCT);
    end
  endfunction

  function automatic void add_spec(bit explicit_pos);
    int pick;
    fmt_bytes.push_back(CH_PCT);
    if (explicit_pos) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        add_number(0);
      end else if (pick == 1) begin
        add_number($urandom_range(9, 99999));
      end else if (pick == 2) begin
        fmt_bytes.push_back(CH_ZERO);
        add_number($urandom_range(1, 8));
      end else begin
        // small positions make repeats, and so class conflicts, likely
        add_number($urandom_range(1, pick < 12 ? 3 : 8));
      end
      fmt_bytes.push_back(CH_DOLLAR);
    end
    repeat ($urandom_range(0, 2)) fmt_bytes.push_back(flag_chars[$urandom_range(0, 4)]);
    if ($urandom_range(0, 1) == 0) add_number($urandom_range(0, 99));
    if ($urandom_range(0, 2) == 0) begin
      fmt_bytes.push_back(CH_DOT);
      if ($urandom_range(0, 1) == 0) add_number($urandom_range(0, 20));
    end
    repeat ($urandom_range(0, 2)) fmt_bytes.push_back(len_chars[$urandom_range(0, 5)]);
    pick = $urandom_range(0, 29);
    if (pick == 0)      fmt_bytes.push_back(CH_N);
    else if (pick == 1) fmt_bytes.push_back(8'($urandom_range(1, 255)));
    else                fmt_bytes.push_back(conv_chars[$urandom_range(0, 7)]);
  endfunction

  function automatic void build_string();
    int  n_specs;
    int  keep;
    bit  explicit_mode;
    fmt_bytes.delete();
    explicit_mode = 1'($urandom_range(0, 1));
    n_specs = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 10) : $urandom_range(0, 3);
    repeat (n_specs) begin
      if ($urandom_range(0, 2) == 0) add_literal();
      add_spec(($urandom_range(0, 14) == 0) ? !explicit_mode : explicit_mode);
    end
    if ($urandom_range(0, 1) == 0) add_literal();
    // noise: stray byte, cut-off string, dangling percent
    if ($urandom_range(0, 9) == 0 && fmt_bytes.size() > 0)
      fmt_bytes.insert($urandom_range(0, fmt_bytes.size() - 1), 8'($urandom_range(1, 255)));
    if ($urandom_range(0, 11) == 0 && fmt_bytes.size() > 0) begin
      keep = $urandom_range(0, fmt_bytes.size() - 1);
      while (fmt_bytes.size() > keep) void'(fmt_bytes.pop_back());
    end
    if ($urandom_range(0, 19) == 0) fmt_bytes.push_back(CH_PCT);
  endfunction

  task automatic send_byte(logic [7:0] c);
    int gap;
    if ($urandom_range(0, 15) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i       <= c;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic send_fmt();
    fmt_bytes.push_back(CH_NUL);
    foreach (fmt_bytes[i]) send_byte(fmt_bytes[i]);
    fmt_bytes.delete();
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // result side: random stalls, quiet stretches, one long hold
  initial begin
    int  gap;
    int  taken;
    bit  quiet;
    taken = 0;
    quiet = 1'b0;
    forever begin
      if (taken == HOLD_AFTER) begin
        out_ready_i <= 1'b0;
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_active <= 1'b0;
      end else begin
        if ($urandom_range(0, 5) == 0) quiet = !quiet;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    bit first;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // trailing percent, "0$" falls back to implicit, saturated position
    add_chars("%");    send_fmt();
    add_chars("%0$d"); send_fmt();
    add_chars("%99$c"); send_fmt();
    add_chars("%n");   send_fmt();
    fmt_bytes.push_back(CH_PCT);
    fmt_bytes.push_back(8'hFF);
    send_fmt();
    // terminator right after a pending width
    add_chars("%5");   send_fmt();
    add_chars("%1$s%1$d"); send_fmt();
    add_chars("%08X%%%s%-+ #3.2hhic"); send_fmt();

    first = 1'b1;
    while (bytes_sent < 500) begin
      build_string();
      send_fmt();
      if (first || (!hold_active && $urandom_range(0, 7) == 0)) drain();
      first = 1'b0;
    end
    in_valid_i <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
